// File: sv/rptdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rptdm_pkg;

  localparam int WidthW = 16;
  localparam int SpeedW = 17;
  localparam int DriveW = 8;

  localparam logic [15:0] TimerPeriodRst = 16'd65535;
  localparam logic [15:0] PulseMinRst    = 16'd800;
  localparam logic [15:0] PulseMaxRst    = 16'd2200;
  localparam logic [7:0]  DeadBandRst    = 8'd15;

  localparam logic [15:0] GuardHi = 16'd1530;
  localparam logic [15:0] GuardLo = 16'd1470;
  localparam logic [15:0] LowRef  = 16'd1000;

  localparam logic signed [SpeedW-1:0] SpeedOffset = 17'sd255;

  // Reciprocal of 470 scaled by 2**33, exact for dividends below 2**24.
  localparam logic [24:0] Recip470      = 25'd18276457;
  localparam int          Recip470Shift = 33;

  // 127 times the reciprocal of 255 scaled by 2**24, exact for inputs up to 510.
  localparam logic [22:0] DriveScale = 23'd8355838;
  localparam int          DriveShift = 24;

  typedef enum logic [1:0] {
    REG_TIMER_PERIOD = 2'd0,
    REG_PULSE_MIN    = 2'd1,
    REG_PULSE_MAX    = 2'd2,
    REG_DEAD_BAND    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACTION_CAPTURE = 1'b0,
    ACTION_TICK    = 1'b1
  } action_t;

  typedef struct packed {
    logic [15:0] timer_period;
    logic [15:0] pulse_min_valid;
    logic [15:0] pulse_max_valid;
    logic [7:0]  dead_band;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/rptdm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rptdm_cfg
  import rptdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timer_period    <= TimerPeriodRst;
      cfg_r.pulse_min_valid <= PulseMinRst;
      cfg_r.pulse_max_valid <= PulseMaxRst;
      cfg_r.dead_band       <= DeadBandRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMER_PERIOD: cfg_r.timer_period    <= cfg_wdata;
        REG_PULSE_MIN:    cfg_r.pulse_min_valid <= cfg_wdata;
        REG_PULSE_MAX:    cfg_r.pulse_max_valid <= cfg_wdata;
        REG_DEAD_BAND:    cfg_r.dead_band       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/rptdm_capture.sv
`timescale 1ns / 1ps
`default_nettype none

module rptdm_capture
  import rptdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       timer_period,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic              in_capture_channel,
  input  wire logic [15:0]       in_capture_time,
  output logic                   tick_valid,
  input  wire logic              tick_stall,
  output logic [WidthW-1:0]      steer_width,
  output logic [WidthW-1:0]      throttle_width
);

  logic              s1_valid_r;
  action_t           s1_action_r;
  logic              s1_ch_r;
  logic [15:0]       s1_time_r;

  logic [15:0]       rise_r [2];
  logic [1:0]        await_r;
  logic [WidthW-1:0] width_r [2];

  logic              cap_fire;
  logic [15:0]       rise_sel;
  logic [WidthW-1:0] width_nxt;

  assign tick_valid = s1_valid_r && (s1_action_r == ACTION_TICK);
  assign in_stall   = tick_valid && tick_stall;
  assign cap_fire   = s1_valid_r && (s1_action_r == ACTION_CAPTURE);

  assign steer_width    = width_r[0];
  assign throttle_width = width_r[1];

  // A falling edge below the rising stamp means the timer rolled over.
  always_comb begin
    rise_sel = rise_r[s1_ch_r];
    if (s1_time_r >= rise_sel) begin
      width_nxt = s1_time_r - rise_sel;
    end else begin
      width_nxt = timer_period - rise_sel + s1_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_action_r <= action_t'(in_action);
      s1_ch_r     <= in_capture_channel;
      s1_time_r   <= in_capture_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r  <= '{default: '0};
      width_r <= '{default: '0};
      await_r <= '0;
    end else if (cap_fire) begin
      if (!await_r[s1_ch_r]) begin
        rise_r[s1_ch_r]  <= s1_time_r;
        await_r[s1_ch_r] <= 1'b1;
      end else begin
        width_r[s1_ch_r] <= width_nxt;
        await_r[s1_ch_r] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/rptdm_speed.sv
`timescale 1ns / 1ps
`default_nettype none

module rptdm_speed
  import rptdm_pkg::*;
(
  input  wire cfg_t                cfg,
  input  wire logic [WidthW-1:0]   width,
  output logic signed [SpeedW-1:0] speed
);

  logic        in_window;
  logic        above;
  logic        below;
  logic [15:0] mag;
  logic [23:0] scaled;
  logic [48:0] prod;
  logic [15:0] quot;
  logic signed [SpeedW-1:0] quot_s;

  assign in_window = (width >= cfg.pulse_min_valid) && (width <= cfg.pulse_max_valid);
  assign above     = width > GuardHi;
  assign below     = width < GuardLo;

  always_comb begin
    if (above) begin
      mag = width - GuardHi;
    end else if (width >= LowRef) begin
      mag = width - LowRef;
    end else begin
      mag = LowRef - width;
    end
  end

  assign scaled = ({8'd0, mag} << 8) - {8'd0, mag};
  assign prod   = 49'(scaled) * 49'(Recip470);
  assign quot   = prod[Recip470Shift +: 16];
  assign quot_s = signed'({1'b0, quot});

  always_comb begin
    if (!in_window) begin
      speed = '0;
    end else if (above) begin
      speed = quot_s;
    end else if (below) begin
      if (width >= LowRef) begin
        speed = quot_s - SpeedOffset;
      end else begin
        speed = -quot_s - SpeedOffset;
      end
    end else begin
      speed = '0;
    end
  end

endmodule

`default_nettype wire

// File: sv/rptdm_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module rptdm_mix
  import rptdm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [7:0]               dead_band,
  input  wire logic                     tick_valid,
  output logic                          tick_stall,
  input  wire logic signed [SpeedW-1:0] steer_speed,
  input  wire logic signed [SpeedW-1:0] throttle_speed,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [DriveW-1:0]             out_left_drive,
  output logic [DriveW-1:0]             out_right_drive
);

  localparam logic signed [17:0] MixLimit = 18'sd255;

  logic                     s2_valid_r;
  logic signed [SpeedW-1:0] steer_r;
  logic signed [SpeedW-1:0] throttle_r;
  logic                     out_valid_r;
  logic [DriveW-1:0]        left_r;
  logic [DriveW-1:0]        right_r;

  logic                     adv_out;
  logic signed [SpeedW-1:0] steer_db;
  logic signed [SpeedW-1:0] throttle_db;
  logic signed [17:0]       left_mix;
  logic signed [17:0]       right_mix;
  logic [DriveW-1:0]        left_nxt;
  logic [DriveW-1:0]        right_nxt;

  function automatic logic signed [SpeedW-1:0] deadband_f(
    input logic signed [SpeedW-1:0] s,
    input logic [7:0]               d
  );
    logic [SpeedW-1:0] mag;
    mag = s[SpeedW-1] ? SpeedW'(-s) : SpeedW'(s);
    if (mag < {{(SpeedW-8){1'b0}}, d}) begin
      return '0;
    end
    return s;
  endfunction

  function automatic logic [DriveW-1:0] drive_f(input logic signed [17:0] m);
    logic signed [17:0] c;
    logic [17:0]        biased;
    logic [31:0]        prod;
    if (m > MixLimit) begin
      c = MixLimit;
    end else if (m < -MixLimit) begin
      c = -MixLimit;
    end else begin
      c = m;
    end
    biased = 18'(c + MixLimit);
    prod   = 32'(biased[8:0]) * 32'(DriveScale);
    return prod[DriveShift +: DriveW];
  endfunction

  assign adv_out         = !out_valid_r || !out_stall;
  assign tick_stall      = s2_valid_r && !adv_out;
  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;

  assign steer_db    = deadband_f(steer_r, dead_band);
  assign throttle_db = deadband_f(throttle_r, dead_band);
  assign left_mix    = 18'(throttle_db) - 18'(steer_db);
  assign right_mix   = 18'(throttle_db) + 18'(steer_db);
  assign left_nxt    = drive_f(left_mix);
  assign right_nxt   = drive_f(right_mix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!tick_stall) begin
        s2_valid_r <= tick_valid;
      end
      if (adv_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      steer_r    <= steer_speed;
      throttle_r <= throttle_speed;
    end
    if (adv_out && s2_valid_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/rc_pulse_tank_drive_mixer.sv
`timescale 1ns / 1ps
`default_nettype none

// Differential drive mixer for two RC receiver channels.
// The input channel carries edge captures (action 0) for steering (channel 0)
// or throttle (channel 1), and frame ticks (action 1). Captures alternate
// rising and falling per channel; a falling capture stores the pulse width.
// Each tick produces one output transaction with the left and right wheel
// commands (0..254, 127 stopped); captures produce none.
// Throughput is one input transaction per cycle while in_stall is low. A tick
// moves from the input register, where the widths are mapped to speeds by one
// reciprocal multiplier per channel, to the mixing stage, where a second
// multiplier per wheel rescales the clamped mix, and on to the output register.
// When the receiver stalls, the result holds in the output register while one
// more tick waits in the mixing stage; further captures keep flowing until a
// tick reaches the input register, which then stalls the input side.
// Reset clears the pipeline, all channel state and loads the register defaults.
// The configuration port writes one register per enabled cycle; the user must
// write only while idle, as the block itself does not enforce it.

module rc_pulse_tank_drive_mixer
  import rptdm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic              in_capture_channel,
  input  wire logic [15:0]       in_capture_time,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DriveW-1:0]      out_left_drive,
  output logic [DriveW-1:0]      out_right_drive
);

  cfg_t                     cfg;
  logic                     tick_valid;
  logic                     tick_stall;
  logic [WidthW-1:0]        steer_width;
  logic [WidthW-1:0]        throttle_width;
  logic signed [SpeedW-1:0] steer_speed;
  logic signed [SpeedW-1:0] throttle_speed;

  rptdm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rptdm_capture u_capture (
    .clk                (clk),
    .rst_n              (rst_n),
    .timer_period       (cfg.timer_period),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_capture_channel (in_capture_channel),
    .in_capture_time    (in_capture_time),
    .tick_valid         (tick_valid),
    .tick_stall         (tick_stall),
    .steer_width        (steer_width),
    .throttle_width     (throttle_width)
  );

  rptdm_speed u_speed_steer (
    .cfg   (cfg),
    .width (steer_width),
    .speed (steer_speed)
  );

  rptdm_speed u_speed_throttle (
    .cfg   (cfg),
    .width (throttle_width),
    .speed (throttle_speed)
  );

  rptdm_mix u_mix (
    .clk             (clk),
    .rst_n           (rst_n),
    .dead_band       (cfg.dead_band),
    .tick_valid      (tick_valid),
    .tick_stall      (tick_stall),
    .steer_speed     (steer_speed),
    .throttle_speed  (throttle_speed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive)
  );

endmodule

`default_nettype wire

// File: sv/rptdm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rptdm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_left_drive,
  input wire logic [7:0] out_right_drive
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Output transaction dropped while stalled.");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_drive) && $stable(out_right_drive))
    else $error("Output payload changed while stalled.");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_drive <= 8'd254) && (out_right_drive <= 8'd254))
    else $error("Drive command out of range.");

  a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("Input stalled while the output side is free.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Pipeline not empty after reset.");

endmodule

bind rc_pulse_tank_drive_mixer rptdm_checker u_rptdm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_left_drive  (out_left_drive),
  .out_right_drive (out_right_drive)
);

`default_nettype wire

// File: dv/tb_rc_pulse_tank_drive_mixer.sv
`timescale 1ns / 1ps

module tb_rc_pulse_tank_drive_mixer;
  import rptdm_pkg::*;

  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 6;
  localparam int NumPhases    = 8;
  localparam int PerPhase     = 206;
  localparam int MaxPrinted   = 50;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    action_t     act;
    logic        ch;
    cfg_reg_t    sel;
    logic [15:0] val;
    logic        pin;
    logic [7:0]  left;
    logic [7:0]  right;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
  } drive_pair_t;

  // Rows with pinned drives can be read straight off the mixing rules; the rest use
  // the predictor.
  localparam stim_row_t DirRows [34] = '{
    '{ROW_ITEM,  ACTION_TICK,    1'b0, REG_TIMER_PERIOD, 16'd0,     1'b1, 8'd127, 8'd127},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd1000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd3000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b0, REG_TIMER_PERIOD, 16'd0,     1'b1, 8'd254, 8'd254},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd100,   1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd2100,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b1, REG_TIMER_PERIOD, 16'd0,     1'b1, 8'd127, 8'd254},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd5000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd6000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b0, REG_TIMER_PERIOD, 16'd0,     1'b1, 8'd0,   8'd127},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd65000, 1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd1000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b0, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd900,   1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b1, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd1469,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd7,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd1537,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b0, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd1000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd5000,  1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b0, REG_TIMER_PERIOD, 16'd10,    1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_PULSE_MIN,    16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_PULSE_MAX,    16'd65535, 1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_DEAD_BAND,    16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_CAPTURE, 1'b1, REG_TIMER_PERIOD, 16'd65535, 1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b1, REG_TIMER_PERIOD, 16'd0,     1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_PULSE_MIN,    16'd3000,  1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_PULSE_MAX,    16'd100,   1'b0, 8'd0,   8'd0},
    '{ROW_WRITE, ACTION_CAPTURE, 1'b0, REG_DEAD_BAND,    16'd255,   1'b0, 8'd0,   8'd0},
    '{ROW_ITEM,  ACTION_TICK,    1'b0, REG_TIMER_PERIOD, 16'd0,     1'b1, 8'd127, 8'd127}
  };

  localparam logic [15:0] PhasePeriod [NumPhases] =
    '{16'd65535, 16'd1, 16'd40000, 16'd20000, 16'd65535, 16'd3000, 16'd65535, 16'd50000};
  localparam logic [15:0] PhaseMin [NumPhases] =
    '{16'd800, 16'd0, 16'd1000, 16'd65535, 16'd0, 16'd900, 16'd1100, 16'd0};
  localparam logic [15:0] PhaseMax [NumPhases] =
    '{16'd2200, 16'd65535, 16'd2000, 16'd0, 16'd65535, 16'd2100, 16'd1900, 16'd3000};
  localparam logic [7:0] PhaseBand [NumPhases] =
    '{8'd15, 8'd0, 8'd255, 8'd40, 8'd7, 8'd100, 8'd30, 8'd1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_TIMER_PERIOD;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  action_t     in_action = ACTION_CAPTURE;
  logic        in_capture_channel = 1'b0;
  logic [15:0] in_capture_time = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_left_drive;
  logic [7:0]  out_right_drive;

  logic        tick_pinned = 1'b0;
  logic [7:0]  pinned_left = 8'd0;
  logic [7:0]  pinned_right = 8'd0;

  logic [15:0] period_q;
  logic [15:0] min_q;
  logic [15:0] max_q;
  logic [7:0]  band_q;
  logic [15:0] rise_stamp [2];
  logic        await_fall [2];
  logic [15:0] pulse_width [2];
  drive_pair_t drive_q [$];

  logic [15:0] cur_period = 16'd65535;
  logic [15:0] cur_min = 16'd800;
  logic [15:0] cur_max = 16'd2200;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_left = 0;
  int          items_sent = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  rc_pulse_tank_drive_mixer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_capture_channel (in_capture_channel),
    .in_capture_time    (in_capture_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pulse_to_speed(input logic [15:0] w);
    int x;
    x = int'(w);
    if (w < min_q || w > max_q) return 0;
    if (x > int'(GuardHi)) return (x - int'(GuardHi)) * 255 / 470;
    if (x < int'(GuardLo)) return (x - int'(LowRef)) * 255 / 470 - 255;
    return 0;
  endfunction

  function automatic int squelch(input int s);
    int d;
    d = int'(band_q);
    if (s > -d && s < d) return 0;
    return s;
  endfunction

  function automatic logic [7:0] wheel_command(input int m);
    int c;
    c = m;
    if (c > 255) c = 255;
    if (c < -255) c = -255;
    return 8'((c + 255) * 254 / 510);
  endfunction

  function automatic drive_pair_t mix_drives();
    int throttle;
    int steering;
    drive_pair_t res;
    throttle = squelch(pulse_to_speed(pulse_width[1]));
    steering = squelch(pulse_to_speed(pulse_width[0]));
    res.left = wheel_command(throttle - steering);
    res.right = wheel_command(throttle + steering);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("%0t mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : monitor
    drive_pair_t want;
    logic [15:0] w;
    if (!rst_n) begin
      period_q = TimerPeriodRst;
      min_q = PulseMinRst;
      max_q = PulseMaxRst;
      band_q = DeadBandRst;
      for (int i = 0; i < 2; i++) begin
        rise_stamp[i] = 16'd0;
        await_fall[i] = 1'b0;
        pulse_width[i] = 16'd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMER_PERIOD: period_q = cfg_wdata;
          REG_PULSE_MIN:    min_q = cfg_wdata;
          REG_PULSE_MAX:    max_q = cfg_wdata;
          REG_DEAD_BAND:    band_q = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACTION_CAPTURE) begin
          if (!await_fall[in_capture_channel]) begin
            rise_stamp[in_capture_channel] = in_capture_time;
            await_fall[in_capture_channel] = 1'b1;
          end else begin
            if (in_capture_time >= rise_stamp[in_capture_channel]) begin
              w = in_capture_time - rise_stamp[in_capture_channel];
            end else begin
              w = period_q - rise_stamp[in_capture_channel] + in_capture_time;
            end
            pulse_width[in_capture_channel] = w;
            await_fall[in_capture_channel] = 1'b0;
          end
        end else begin
          want = mix_drives();
          if (tick_pinned) begin
            want.left = pinned_left;
            want.right = pinned_right;
          end
          drive_q.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("unexpected drive transaction left=%0d right=%0d",
                                    out_left_drive, out_right_drive));
        end else begin
          want = drive_q.pop_front();
          if (out_left_drive !== want.left) begin
            report_mismatch($sformatf("left_drive got %0d want %0d", out_left_drive,
                                      want.left));
          end
          if (out_right_drive !== want.right) begin
            report_mismatch($sformatf("right_drive got %0d want %0d", out_right_drive,
                                      want.right));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_rc_pulse_tank_drive_mixer: errors");
      $finish;
    end
  end

  task automatic send_item(input action_t act, input logic ch, input logic [15:0] stamp,
                           input logic pin, input logic [7:0] pl, input logic [7:0] pr);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(49) == 0) begin
      quiet_left = 30;
    end
    if (quiet_left == 0) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_capture_channel <= ch;
    in_capture_time <= stamp;
    tick_pinned <= pin;
    pinned_left <= pl;
    pinned_right <= pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_width();
    logic [15:0] bound;
    case ($urandom_range(4))
      0, 1: return 16'($urandom_range(2100, 900));
      2: return 16'($urandom_range(1545, 1455));
      3: begin
        bound = $urandom_range(1) ? cur_min : cur_max;
        return bound + 16'($urandom_range(6)) - 16'd3;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int target;
    int pick;
    logic ch;
    logic [15:0] w;
    logic [15:0] rise;
    logic [15:0] fall;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DirRows[i]) begin
      if (DirRows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DirRows[i].sel, DirRows[i].val);
      end else begin
        send_item(DirRows[i].act, DirRows[i].ch, DirRows[i].val, DirRows[i].pin,
                  DirRows[i].left, DirRows[i].right);
      end
    end
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      cur_period = PhasePeriod[p];
      cur_min = PhaseMin[p];
      cur_max = PhaseMax[p];
      write_reg(REG_TIMER_PERIOD, cur_period);
      write_reg(REG_PULSE_MIN, cur_min);
      write_reg(REG_PULSE_MAX, cur_max);
      write_reg(REG_DEAD_BAND, {8'($urandom), PhaseBand[p]});
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      target = items_sent + PerPhase;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 28) begin
          send_item(ACTION_TICK, 1'($urandom), 16'($urandom), 1'b0, 8'd0, 8'd0);
        end else if (pick < 90) begin
          ch = 1'($urandom);
          w = pick_width();
          rise = 16'($urandom_range(32'(cur_period) - 1));
          fall = 16'((32'(rise) + 32'(w)) % 32'(cur_period));
          send_item(ACTION_CAPTURE, ch, rise, 1'b0, 8'd0, 8'd0);
          if ($urandom_range(4) == 0) begin
            send_item(ACTION_TICK, 1'($urandom), 16'($urandom), 1'b0, 8'd0, 8'd0);
          end
          send_item(ACTION_CAPTURE, ch, fall, 1'b0, 8'd0, 8'd0);
        end else begin
          send_item(ACTION_CAPTURE, 1'($urandom), 16'($urandom), 1'b0, 8'd0, 8'd0);
        end
      end
    end
    settle();
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("tb_rc_pulse_tank_drive_mixer: clean");
    end else begin
      $display("tb_rc_pulse_tank_drive_mixer: errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rptdm_pkg.sv
sv/rptdm_cfg.sv
sv/rptdm_capture.sv
sv/rptdm_speed.sv
sv/rptdm_mix.sv
sv/rc_pulse_tank_drive_mixer.sv
sv/rptdm_checker.sv
dv/tb_rc_pulse_tank_drive_mixer.sv
